// ===== sv/qrt_pkg.sv =====
// Shared types, widths, codes and helper functions of the quaternion rigid transform.
package qrt_pkg;

	localparam int VEC_W    = 32;             // Q16.16 vector component
	localparam int QUAT_W   = 16;             // Q1.14 quaternion component
	localparam int SCL_W    = 16;             // Q8.8 scale
	localparam int SCL_SH   = 8;
	localparam int ROT_SH   = 14;
	localparam int SCL_RND  = 1 << (SCL_SH - 1);
	localparam int ROT_RND  = 1 << (ROT_SH - 1);
	localparam int VW       = VEC_W + 1;      // vector after translation subtract
	localparam int QW       = QUAT_W + 1;     // quaternion with negation headroom
	localparam int SPW      = VEC_W + SCL_W + 1;
	localparam int P1W      = VW + QW;
	localparam int TSUM_W   = P1W + 2;
	localparam int TW       = TSUM_W - ROT_SH;
	localparam int P2W      = TW + QW;
	localparam int RSUM_W   = P2W + 2;
	localparam int RW       = RSUM_W - ROT_SH;
	localparam int FW       = RW + 1;         // rotated value plus translation
	localparam int NW       = RW + SCL_SH + 1; // scaled dividend magnitude
	localparam int HW       = NW - VEC_W;
	localparam int DIV_STEPS = VEC_W;
	localparam int DIV_STEPS_PER_STAGE = 4;

	localparam logic [VEC_W-1:0] INT_MAX = {1'b0, {(VEC_W-1){1'b1}}};
	localparam logic [VEC_W-1:0] INT_MIN = {1'b1, {(VEC_W-1){1'b0}}};

	localparam logic [2:0] OP_POS     = 3'd0;
	localparam logic [2:0] OP_VEC     = 3'd1;
	localparam logic [2:0] OP_VEC_NS  = 3'd2;
	localparam logic [2:0] OP_INV_POS = 3'd3;
	localparam logic [2:0] OP_INV_VEC = 3'd4;
	localparam logic [2:0] OP_INV_NS  = 3'd5;

	typedef enum logic [2:0] {
		REG_ROT_X   = 3'd0,
		REG_ROT_Y   = 3'd1,
		REG_ROT_Z   = 3'd2,
		REG_ROT_W   = 3'd3,
		REG_SHIFT_X = 3'd4,
		REG_SHIFT_Y = 3'd5,
		REG_SHIFT_Z = 3'd6,
		REG_SCALE   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [QUAT_W-1:0]           rot_x;
		logic [QUAT_W-1:0]           rot_y;
		logic [QUAT_W-1:0]           rot_z;
		logic [QUAT_W-1:0]           rot_w;
		logic [2:0][VEC_W-1:0]       shift;
		logic [2:0][SCL_W-1:0]       scale;
	} cfg_t;

	typedef struct packed {
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] z;
		logic signed [QW-1:0] w;
	} quat_t;

	typedef struct packed {
		logic [2:0]            op;
		logic [2:0][VW-1:0]    v;
		logic                  ov;
	} front_t;

	typedef struct packed {
		logic [2:0]            op;
		logic [2:0][RW-1:0]    r;
		logic                  ov;
	} rot_t;

	typedef struct packed {
		logic              div;
		logic              neg;
		logic              sat;
		logic              zs;
		logic [SCL_W-1:0]  rem;
		logic [VEC_W-1:0]  dq;
	} lane_t;

	typedef struct packed {
		lane_t [2:0] ln;
		logic        ov;
	} div_t;

	typedef struct packed {
		logic [2:0][VEC_W-1:0] res;
		logic                  ov;
		logic                  zs;
	} res_t;

	function automatic logic is_inverse(input logic [2:0] op);
		return (op == OP_INV_POS) || (op == OP_INV_VEC) || (op == OP_INV_NS);
	endfunction

	// Quaternion as given for forward modes, its conjugate for inverse modes.
	function automatic quat_t pick_quat(input cfg_t cfg, input logic inv);
		quat_t q;
		q.x = QW'($signed(cfg.rot_x));
		q.y = QW'($signed(cfg.rot_y));
		q.z = QW'($signed(cfg.rot_z));
		q.w = QW'($signed(cfg.rot_w));
		if (inv) begin
			q.x = -q.x;
			q.y = -q.y;
			q.z = -q.z;
		end
		return q;
	endfunction

	// Clamp to signed 32 bits; the top bit returns the saturation flag.
	function automatic logic [VEC_W:0] sat32(input logic signed [FW-1:0] v);
		logic signed [FW-1:0] mx;
		logic signed [FW-1:0] mn;
		mx = $signed({{(FW-VEC_W){1'b0}}, INT_MAX});
		mn = $signed({{(FW-VEC_W){1'b1}}, INT_MIN});
		if (v > mx)
			return {1'b1, INT_MAX};
		else if (v < mn)
			return {1'b1, INT_MIN};
		return {1'b0, v[VEC_W-1:0]};
	endfunction

	// One restoring division step: bring in a dividend bit, shift in a quotient bit.
	function automatic lane_t div_step(input lane_t l, input logic [SCL_W-1:0] sc);
		lane_t            o;
		logic [SCL_W:0]   rem_w;
		logic             ge;
		o     = l;
		rem_w = {l.rem, l.dq[VEC_W-1]};
		ge    = rem_w >= {1'b0, sc};
		if (l.div) begin
			o.rem = ge ? SCL_W'(rem_w - {1'b0, sc}) : rem_w[SCL_W-1:0];
			o.dq  = {l.dq[VEC_W-2:0], ge};
		end
		return o;
	endfunction

endpackage

// ===== sv/quaternion_rigid_transform_top.sv =====
// Top level of the quaternion rigid transform: register file and pipeline.
//
// Transforms Q16.16 vectors by a configured scale, unit-quaternion rotation and
// translation, forward or inverse, one vector per item on a valid/ready channel.
// Results come out on a second valid/ready channel with saturated components,
// an overflow flag and a zero-scale flag.
// Configuration sits behind an APB-style port, 64-bit data, register i at 8*i;
// write it only while the pipeline is empty. pready is tied high.
// Throughput: one item per cycle while the receiver keeps res_ready high. The
// restoring divider of the inverse modes resolves DIV_STEPS_PER_STAGE quotient bits
// per stage; forward items pass through the same stages so order is kept.
// Each stage holds its item while the next one is full, so bubbles close up and
// a stalled receiver backs the pipe up stage by stage; vec_ready drops only when
// every stage holds an item. Nothing is dropped or repeated.
// Reset clears all valid bits and loads the identity transform.
module quaternion_rigid_transform_top #(
	parameter int DIV_STEPS_PER_STAGE = qrt_pkg::DIV_STEPS_PER_STAGE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        vec_valid,
	output logic        vec_ready,
	input  logic [2:0]  operation,
	input  logic [31:0] vec_x,
	input  logic [31:0] vec_y,
	input  logic [31:0] vec_z,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [31:0] res_x,
	output logic [31:0] res_y,
	output logic [31:0] res_z,
	output logic        overflow,
	output logic        zero_scale
);
	import qrt_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t widx;
	logic     wr_en;

	logic     fr_valid, fr_ready;
	front_t   fr_data;
	logic     ro_valid, ro_ready;
	rot_t     ro_data;
	res_t     out_data;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign widx   = reg_idx_t'(paddr[5:3]);

	// Write the addressed register, masked to its width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_x <= '0;
			cfg_q.rot_y <= '0;
			cfg_q.rot_z <= '0;
			cfg_q.rot_w <= QUAT_W'(16384);
			cfg_q.shift <= '0;
			cfg_q.scale <= {3{SCL_W'(256)}};
		end else if (wr_en) begin
			case (widx)
				REG_ROT_X:   cfg_q.rot_x    <= pwdata[QUAT_W-1:0];
				REG_ROT_Y:   cfg_q.rot_y    <= pwdata[QUAT_W-1:0];
				REG_ROT_Z:   cfg_q.rot_z    <= pwdata[QUAT_W-1:0];
				REG_ROT_W:   cfg_q.rot_w    <= pwdata[QUAT_W-1:0];
				REG_SHIFT_X: cfg_q.shift[0] <= pwdata[VEC_W-1:0];
				REG_SHIFT_Y: cfg_q.shift[1] <= pwdata[VEC_W-1:0];
				REG_SHIFT_Z: cfg_q.shift[2] <= pwdata[VEC_W-1:0];
				REG_SCALE:   cfg_q.scale    <= pwdata[3*SCL_W-1:0];
				default:     cfg_q          <= cfg_q;
			endcase
		end
	end

	// Read back the raw register bits, zero extended.
	always_comb begin
		case (widx)
			REG_ROT_X:   prdata = 64'(cfg_q.rot_x);
			REG_ROT_Y:   prdata = 64'(cfg_q.rot_y);
			REG_ROT_Z:   prdata = 64'(cfg_q.rot_z);
			REG_ROT_W:   prdata = 64'(cfg_q.rot_w);
			REG_SHIFT_X: prdata = 64'(cfg_q.shift[0]);
			REG_SHIFT_Y: prdata = 64'(cfg_q.shift[1]);
			REG_SHIFT_Z: prdata = 64'(cfg_q.shift[2]);
			REG_SCALE:   prdata = 64'(cfg_q.scale);
			default:     prdata = '0;
		endcase
	end

	// Scale or subtract translation, pick the vector.
	qrt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (vec_valid),
		.up_ready (vec_ready),
		.up_op    (operation),
		.up_vec   ({vec_z, vec_y, vec_x}),
		.dn_valid (fr_valid),
		.dn_ready (fr_ready),
		.dn_data  (fr_data)
	);

	// Rotate by q v q* (forward) or q* v q (inverse).
	qrt_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (fr_valid),
		.up_ready (fr_ready),
		.up_data  (fr_data),
		.dn_valid (ro_valid),
		.dn_ready (ro_ready),
		.dn_data  (ro_data)
	);

	// Translate, or divide by scale, then clamp into the output register.
	qrt_divide #(
		.STEPS (DIV_STEPS_PER_STAGE)
	) u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (ro_valid),
		.up_ready (ro_ready),
		.up_data  (ro_data),
		.dn_valid (res_valid),
		.dn_ready (res_ready),
		.dn_data  (out_data)
	);

	assign res_x      = out_data.res[0];
	assign res_y      = out_data.res[1];
	assign res_z      = out_data.res[2];
	assign overflow   = out_data.ov;
	assign zero_scale = out_data.zs;

endmodule

// ===== sv/qrt_front.sv =====
// Front stages: scale or translation subtract, then pick the vector to rotate.
module qrt_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qrt_pkg::cfg_t                 cfg,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic [2:0]                    up_op,
	input  logic [2:0][qrt_pkg::VEC_W-1:0] up_vec,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output qrt_pkg::front_t               dn_data
);
	import qrt_pkg::*;

	logic                    vld_s1, vld_s2;
	logic                    rdy_s1, rdy_s2;
	logic [2:0]              op_s1;
	logic [2:0][VEC_W-1:0]   raw_s1;
	logic signed [SPW-1:0]   sp_s1  [3];
	logic signed [VW-1:0]    dif_s1 [3];
	logic signed [SPW-1:0]   sp_c   [3];
	logic signed [VW-1:0]    dif_c  [3];
	front_t                  nxt_c;
	front_t                  dat_s2;

	assign rdy_s2   = !vld_s2 || dn_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign up_ready = rdy_s1;
	assign dn_valid = vld_s2;
	assign dn_data  = dat_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sp_c[i]  = $signed(up_vec[i]) * $signed({1'b0, cfg.scale[i]});
			dif_c[i] = $signed({up_vec[i][VEC_W-1], up_vec[i]})
				- $signed({cfg.shift[i][VEC_W-1], cfg.shift[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			op_s1  <= up_op;
			raw_s1 <= up_vec;
			for (int i = 0; i < 3; i++) begin
				sp_s1[i]  <= sp_c[i];
				dif_s1[i] <= dif_c[i];
			end
		end
	end

	always_comb begin
		logic signed [SPW-1:0] rnd;
		logic [VEC_W:0]        sat;
		logic                  any_ov;
		any_ov    = 1'b0;
		nxt_c.op  = op_s1;
		nxt_c.v   = '0;
		for (int i = 0; i < 3; i++) begin
			rnd    = (sp_s1[i] + SPW'(SCL_RND)) >>> SCL_SH;
			sat    = sat32(rnd[FW-1:0]);
			any_ov = any_ov | sat[VEC_W];
			case (op_s1)
				OP_POS, OP_VEC:                   nxt_c.v[i] = {sat[VEC_W-1], sat[VEC_W-1:0]};
				OP_VEC_NS, OP_INV_VEC, OP_INV_NS: nxt_c.v[i] = {raw_s1[i][VEC_W-1], raw_s1[i]};
				OP_INV_POS:                       nxt_c.v[i] = dif_s1[i];
				default:                          nxt_c.v[i] = '0;
			endcase
		end
		nxt_c.ov = any_ov && ((op_s1 == OP_POS) || (op_s1 == OP_VEC));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			dat_s2 <= nxt_c;
		end
	end

endmodule

// ===== sv/qrt_rotate.sv =====
// Rotation stages: t = q (v,0), then r = t conj(q), each product registered then summed.
module qrt_rotate (
	input  logic             clk,
	input  logic             arst_n,
	input  qrt_pkg::cfg_t    cfg,
	input  logic             up_valid,
	output logic             up_ready,
	input  qrt_pkg::front_t  up_data,
	output logic             dn_valid,
	input  logic             dn_ready,
	output qrt_pkg::rot_t    dn_data
);
	import qrt_pkg::*;

	logic                  vld_s3, vld_s4, vld_s5, vld_s6;
	logic                  rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	logic [2:0]            op_s3, op_s4, op_s5, op_s6;
	logic                  ov_s3, ov_s4, ov_s5, ov_s6;
	logic signed [P1W-1:0] p_s3 [12];
	logic signed [TW-1:0]  t_s4 [4];   // x, y, z, w
	logic signed [P2W-1:0] p_s5 [12];
	logic [2:0][RW-1:0]    r_s6;
	logic signed [P1W-1:0] p1_c [12];
	logic signed [TW-1:0]  t_c  [4];
	logic signed [P2W-1:0] p2_c [12];
	logic [2:0][RW-1:0]    r_c;

	assign rdy_s6   = !vld_s6 || dn_ready;
	assign rdy_s5   = !vld_s5 || rdy_s6;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign up_ready = rdy_s3;
	assign dn_valid = vld_s6;
	assign dn_data  = '{op: op_s6, r: r_s6, ov: ov_s6};

	always_comb begin
		quat_t                q;
		logic signed [VW-1:0] v0, v1, v2;
		q  = pick_quat(cfg, is_inverse(up_data.op));
		v0 = $signed(up_data.v[0]);
		v1 = $signed(up_data.v[1]);
		v2 = $signed(up_data.v[2]);
		p1_c[0]  = q.w * v0;  p1_c[1]  = q.y * v2;  p1_c[2]  = q.z * v1;
		p1_c[3]  = q.w * v1;  p1_c[4]  = q.x * v2;  p1_c[5]  = q.z * v0;
		p1_c[6]  = q.w * v2;  p1_c[7]  = q.x * v1;  p1_c[8]  = q.y * v0;
		p1_c[9]  = q.x * v0;  p1_c[10] = q.y * v1;  p1_c[11] = q.z * v2;
	end

	always_comb begin
		logic signed [TSUM_W-1:0] s [4];
		logic signed [TSUM_W-1:0] rs;
		s[0] = TSUM_W'(p_s3[0]) + TSUM_W'(p_s3[1]) - TSUM_W'(p_s3[2]);
		s[1] = TSUM_W'(p_s3[3]) - TSUM_W'(p_s3[4]) + TSUM_W'(p_s3[5]);
		s[2] = TSUM_W'(p_s3[6]) + TSUM_W'(p_s3[7]) - TSUM_W'(p_s3[8]);
		s[3] = -TSUM_W'(p_s3[9]) - TSUM_W'(p_s3[10]) - TSUM_W'(p_s3[11]);
		for (int i = 0; i < 4; i++) begin
			rs     = (s[i] + TSUM_W'(ROT_RND)) >>> ROT_SH;
			t_c[i] = rs[TW-1:0];
		end
	end

	always_comb begin
		quat_t q;
		q = pick_quat(cfg, is_inverse(op_s4));
		p2_c[0]  = t_s4[3] * q.x;  p2_c[1]  = t_s4[0] * q.w;
		p2_c[2]  = t_s4[1] * q.z;  p2_c[3]  = t_s4[2] * q.y;
		p2_c[4]  = t_s4[3] * q.y;  p2_c[5]  = t_s4[0] * q.z;
		p2_c[6]  = t_s4[1] * q.w;  p2_c[7]  = t_s4[2] * q.x;
		p2_c[8]  = t_s4[3] * q.z;  p2_c[9]  = t_s4[0] * q.y;
		p2_c[10] = t_s4[1] * q.x;  p2_c[11] = t_s4[2] * q.w;
	end

	always_comb begin
		logic signed [RSUM_W-1:0] s [3];
		logic signed [RSUM_W-1:0] rs;
		s[0] = -RSUM_W'(p_s5[0]) + RSUM_W'(p_s5[1]) - RSUM_W'(p_s5[2]) + RSUM_W'(p_s5[3]);
		s[1] = -RSUM_W'(p_s5[4]) + RSUM_W'(p_s5[5]) + RSUM_W'(p_s5[6]) - RSUM_W'(p_s5[7]);
		s[2] = -RSUM_W'(p_s5[8]) - RSUM_W'(p_s5[9]) + RSUM_W'(p_s5[10]) + RSUM_W'(p_s5[11]);
		for (int i = 0; i < 3; i++) begin
			rs     = (s[i] + RSUM_W'(ROT_RND)) >>> ROT_SH;
			r_c[i] = rs[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s3) vld_s3 <= up_valid;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			op_s3 <= up_data.op;
			ov_s3 <= up_data.ov;
			for (int i = 0; i < 12; i++) p_s3[i] <= p1_c[i];
		end
		if (rdy_s4) begin
			op_s4 <= op_s3;
			ov_s4 <= ov_s3;
			for (int i = 0; i < 4; i++) t_s4[i] <= t_c[i];
		end
		if (rdy_s5) begin
			op_s5 <= op_s4;
			ov_s5 <= ov_s4;
			for (int i = 0; i < 12; i++) p_s5[i] <= p2_c[i];
		end
		if (rdy_s6) begin
			op_s6 <= op_s5;
			ov_s6 <= ov_s5;
			r_s6  <= r_c;
		end
	end

endmodule

// ===== sv/qrt_divide.sv =====
// Back stages: translate or set up the scale division, pipelined divider, final clamp.
module qrt_divide #(
	parameter int STEPS = qrt_pkg::DIV_STEPS_PER_STAGE
) (
	input  logic           clk,
	input  logic           arst_n,
	input  qrt_pkg::cfg_t  cfg,
	input  logic           up_valid,
	output logic           up_ready,
	input  qrt_pkg::rot_t  up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output qrt_pkg::res_t  dn_data
);
	import qrt_pkg::*;

	localparam int NST = DIV_STEPS / STEPS;

	logic  vld_s7, rdy_s7;
	div_t  dat_s7, prep_c;
	logic  vld_s8 [NST];
	logic  rdy_s8 [NST+1];
	div_t  dat_s8 [NST];
	logic  vld_s16, rdy_s16;
	res_t  dat_s16, fin_c;

	assign rdy_s16     = !vld_s16 || dn_ready;
	assign rdy_s8[NST] = rdy_s16;
	assign rdy_s7      = !vld_s7 || rdy_s8[0];
	assign up_ready    = rdy_s7;
	assign dn_valid    = vld_s16;
	assign dn_data     = dat_s16;

	always_comb begin
		logic signed [RW-1:0] rr;
		logic signed [FW-1:0] fwd;
		logic [VEC_W:0]       fs;
		logic [RW-1:0]        mag;
		logic [NW-1:0]        nn;
		logic [HW-1:0]        hi;
		logic                 any_ov;
		any_ov = 1'b0;
		prep_c = '0;
		for (int i = 0; i < 3; i++) begin
			rr  = $signed(up_data.r[i]);
			fwd = FW'(rr);
			if (up_data.op == OP_POS)
				fwd = fwd + FW'($signed(cfg.shift[i]));
			fs  = sat32(fwd);
			mag = rr[RW-1] ? RW'(-rr) : RW'(rr);
			nn  = NW'({mag, {SCL_SH{1'b0}}}) + NW'(cfg.scale[i][SCL_W-1:1]);
			hi  = nn[NW-1:VEC_W];
			case (up_data.op)
				OP_INV_POS, OP_INV_VEC: begin
					prep_c.ln[i].div = 1'b1;
					prep_c.ln[i].neg = rr[RW-1];
					prep_c.ln[i].sat = hi >= HW'(cfg.scale[i]);
					prep_c.ln[i].zs  = cfg.scale[i] == '0;
					prep_c.ln[i].rem = hi[SCL_W-1:0];
					prep_c.ln[i].dq  = nn[VEC_W-1:0];
				end
				OP_POS, OP_VEC, OP_VEC_NS, OP_INV_NS: begin
					prep_c.ln[i].dq = fs[VEC_W-1:0];
					any_ov          = any_ov | fs[VEC_W];
				end
				default: prep_c.ln[i] = '0;
			endcase
		end
		prep_c.ov = up_data.ov | any_ov;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (rdy_s7) begin
			vld_s7 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7) dat_s7 <= prep_c;
	end

	for (genvar k = 0; k < NST; k++) begin : g_div
		div_t src_c, nxt_c;
		logic src_vld;

		assign src_c   = (k == 0) ? dat_s7 : dat_s8[(k == 0) ? 0 : k-1];
		assign src_vld = (k == 0) ? vld_s7 : vld_s8[(k == 0) ? 0 : k-1];
		assign rdy_s8[k] = !vld_s8[k] || rdy_s8[k+1];

		always_comb begin
			nxt_c = src_c;
			for (int j = 0; j < STEPS; j++) begin
				for (int i = 0; i < 3; i++) begin
					nxt_c.ln[i] = div_step(nxt_c.ln[i], cfg.scale[i]);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s8[k] <= 1'b0;
			end else if (rdy_s8[k]) begin
				vld_s8[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_s8[k]) dat_s8[k] <= nxt_c;
		end
	end

	// Restore the sign of each quotient and clamp it.
	always_comb begin
		lane_t l;
		logic  ov, zs;
		ov = dat_s8[NST-1].ov;
		zs = 1'b0;
		for (int i = 0; i < 3; i++) begin
			l = dat_s8[NST-1].ln[i];
			fin_c.res[i] = l.dq;
			if (l.div) begin
				if (l.zs) begin
					fin_c.res[i] = '0;
					zs           = 1'b1;
				end else if (l.sat) begin
					fin_c.res[i] = l.neg ? INT_MIN : INT_MAX;
					ov           = 1'b1;
				end else if (!l.neg) begin
					if (l.dq[VEC_W-1]) begin
						fin_c.res[i] = INT_MAX;
						ov           = 1'b1;
					end
				end else if (l.dq > INT_MIN) begin
					fin_c.res[i] = INT_MIN;
					ov           = 1'b1;
				end else begin
					fin_c.res[i] = VEC_W'(0) - l.dq;
				end
			end
		end
		fin_c.ov = ov;
		fin_c.zs = zs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s16 <= 1'b0;
		end else if (rdy_s16) begin
			vld_s16 <= vld_s8[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s16) dat_s16 <= fin_c;
	end

	a_stall_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		!up_ready |-> (vld_s16 && !dn_ready))
		else $error("input stalled while output side is free");

	a_prep_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s7 && rdy_s8[0]) |=> vld_s8[0])
		else $error("item lost leaving the division setup stage");

	a_zero_lane: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s16 && dat_s16.zs) |->
		(dat_s16.res[0] == '0 || dat_s16.res[1] == '0 || dat_s16.res[2] == '0))
		else $error("zero scale flagged without a zeroed component");

endmodule
